### rtl/core/mhff_pkg.sv
// ============================================================================
// MIME header field finder - shared definitions
// Types, constants and byte helpers used by the front, back and top level.
// ============================================================================
package mhff_pkg;

   localparam int LINE_COPY_MAX  = 1024;
   localparam int COPY_CAP       = LINE_COPY_MAX - 1;
   localparam int LINE_LEN_W     = $clog2(LINE_COPY_MAX);
   localparam int MAX_NAME_BYTES = 8;
   localparam int PREFIX_BYTES   = 8;
   localparam int VALUE_LEN_MAX  = 1023;

   // Queue between the classifier and the line engine.
   localparam int FQ_DEPTH = 4;
   localparam int FQ_AW    = $clog2(FQ_DEPTH);
   localparam int FQ_CW    = $clog2(FQ_DEPTH + 1);

   // Result queue at the output.
   localparam int RQ_DEPTH = 2;
   localparam int RQ_AW    = $clog2(RQ_DEPTH);
   localparam int RQ_CW    = $clog2(RQ_DEPTH + 1);

   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_VT    = 8'h0B;
   localparam logic [7:0] CHAR_FF    = 8'h0C;
   localparam logic [7:0] CHAR_COLON = 8'h3A;

   // Line terminator tracker codes.
   localparam logic [1:0] TT_IN_LINE     = 2'd0;
   localparam logic [1:0] TT_AFTER_LF    = 2'd1;
   localparam logic [1:0] TT_AFTER_LF_CR = 2'd2;

   typedef enum logic [1:0] {
      CSR_NAME_CHARS    = 2'd0,
      CSR_NAME_LENGTH   = 2'd1,
      CSR_PREFIX_CHARS  = 2'd2,
      CSR_PREFIX_LENGTH = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      PH_NAME       = 3'd0,
      PH_SKIP       = 3'd1,
      PH_PREFIX     = 3'd2,
      PH_PREFIX_END = 3'd3,
      PH_VALUE      = 3'd4,
      PH_IGNORE     = 3'd5
   } line_phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_item_type;

   typedef struct packed {
      logic        found;
      logic [15:0] value_start;
      logic [9:0]  value_length;
   } rsp_item_type;

   typedef struct packed {
      logic [63:0] name_chars;
      logic [3:0]  name_length;
      logic [63:0] prefix_chars;
      logic [3:0]  prefix_length;
   } cfg_type;

   typedef struct packed {
      logic [7:0] folded;
      logic       is_line_end;
      logic       is_lf;
      logic       is_space;
      logic       is_colon;
      logic       is_letter;
      logic       last;
   } class_item_type;

   typedef struct packed {
      logic           valid;
      class_item_type item;
   } front_out_type;

   function automatic logic [7:0] fold_byte(input logic [7:0] c);
      return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
   endfunction

endpackage

### rtl/core/mime_header_field_finder.sv
// ============================================================================
// MIME header field finder - top level
// Configuration registers and the front end / line engine pair.
// ============================================================================
// Takes one header byte per cycle while the input queue has room: a
// classifying front end feeds a four-request queue, and the line engine
// retires one request per cycle unless its two-entry result queue is full and not popped.
// Each accepted byte is held in the input queue, and the result that it
// causes is written into the result queue, whose head the rsp_ ports show.
// Each message gives exactly one result (found, or not-found on a
// blank line or the last byte). Configuration registers are written through
// the csr_ port, which is always ready, and should only change between
// messages.
module mime_header_field_finder (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   input  mhff_pkg::req_item_type req_data,
   output logic                   req_full,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output mhff_pkg::rsp_item_type rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  mhff_pkg::csr_index_type csr_index,
   input  logic [63:0]            csr_data
);
   import mhff_pkg::*;

   cfg_type       cfg_ff;
   front_out_type fq_out;
   logic          fq_take;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.name_chars    <= '0;
         cfg_ff.name_length   <= 4'd1;
         cfg_ff.prefix_chars  <= '0;
         cfg_ff.prefix_length <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_NAME_CHARS:    cfg_ff.name_chars    <= csr_data;
            CSR_NAME_LENGTH:   cfg_ff.name_length   <= csr_data[3:0];
            CSR_PREFIX_CHARS:  cfg_ff.prefix_chars  <= csr_data;
            CSR_PREFIX_LENGTH: cfg_ff.prefix_length <= csr_data[3:0];
            default:           cfg_ff               <= cfg_ff;
         endcase
      end
   end

   mhff_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_data (req_data),
      .req_full (req_full),
      .fq_out   (fq_out),
      .fq_take  (fq_take)
   );

   mhff_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .fq_out    (fq_out),
      .fq_take   (fq_take),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

### rtl/core/mhff_front.sv
// ============================================================================
// MIME header field finder - front end
// Accepts message bytes, classifies them and holds them in a short queue
// for the line engine.
// ============================================================================
module mhff_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   input  mhff_pkg::req_item_type req_data,
   output logic                  req_full,
   output mhff_pkg::front_out_type fq_out,
   input  logic                  fq_take
);
   import mhff_pkg::*;

   class_item_type        slot_ff [FQ_DEPTH];
   logic [FQ_AW-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [FQ_AW-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [FQ_CW-1:0]      cnt_ff, cnt_in;
   class_item_type        cls;
   logic                  push_ok;
   logic                  pop_ok;
   logic [7:0]            c;

   always_comb begin
      c               = req_data.data_byte;
      cls.folded      = fold_byte(c);
      cls.is_line_end = (c == CHAR_CR) || (c == CHAR_LF);
      cls.is_lf       = (c == CHAR_LF);
      cls.is_space    = (c == CHAR_SPACE) || (c == CHAR_TAB) ||
                        (c == CHAR_VT) || (c == CHAR_FF);
      cls.is_colon    = (c == CHAR_COLON);
      cls.is_letter   = (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
      cls.last        = req_data.last_byte;
   end

   assign req_full     = (cnt_ff == FQ_CW'(FQ_DEPTH));
   assign push_ok      = req_push && !req_full;
   assign pop_ok       = fq_take && (cnt_ff != '0);
   assign fq_out.valid = (cnt_ff != '0);
   assign fq_out.item  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push_ok ? wr_ptr_ff + FQ_AW'(1) : wr_ptr_ff;
      rd_ptr_in = pop_ok ? rd_ptr_ff + FQ_AW'(1) : rd_ptr_ff;
      cnt_in    = cnt_ff + FQ_CW'(push_ok) - FQ_CW'(pop_ok);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         slot_ff[wr_ptr_ff] <= cls;
      end
   end

endmodule

### rtl/core/mhff_back.sv
// ============================================================================
// MIME header field finder - line engine
// Runs the per-line matching state machine on classified bytes and queues
// the single result of each message.
// ============================================================================
module mhff_back (
   input  logic                    clock,
   input  logic                    reset,
   input  mhff_pkg::cfg_type       cfg,
   input  mhff_pkg::front_out_type fq_out,
   output logic                    fq_take,
   output logic                    rsp_empty,
   input  logic                    rsp_pop,
   output mhff_pkg::rsp_item_type  rsp_data
);
   import mhff_pkg::*;

   typedef struct packed {
      logic        hit;
      logic [15:0] start;
      logic [9:0]  len;
   } finish_type;

   line_phase_type        phase_ff, phase_in;
   logic [3:0]            mi_ff, mi_in;
   logic [15:0]           bp_ff, bp_in;
   logic [LINE_LEN_W-1:0] ll_ff, ll_in;
   logic [15:0]           cs_ff, cs_in;
   logic [1:0]            tt_ff, tt_in;
   logic                  sd_ff, sd_in;

   rsp_item_type          rq_slot_ff [RQ_DEPTH];
   logic [RQ_AW-1:0]      rq_wr_ff, rq_rd_ff;
   logic [RQ_CW-1:0]      rq_cnt_ff;

   logic [3:0]            nlen;
   logic [3:0]            plen;
   logic                  emit_v;
   rsp_item_type          res;
   logic                  rq_pop_ok;

   function automatic logic in_copy(input line_phase_type p);
      return (p == PH_SKIP) || (p == PH_PREFIX) || (p == PH_PREFIX_END) ||
             (p == PH_VALUE);
   endfunction

   function automatic finish_type finish(input line_phase_type p, input logic [3:0] pl,
                                         input logic [15:0] cs, input logic [15:0] e);
      finish_type  f;
      logic [15:0] d;
      d       = e - cs;
      f.hit   = ((p == PH_SKIP) && (pl == 4'd0)) || (p == PH_PREFIX_END) ||
                (p == PH_VALUE);
      f.start = (p == PH_SKIP) ? e : cs;
      if (p == PH_SKIP) begin
         f.len = '0;
      end else if (d > 16'(VALUE_LEN_MAX)) begin
         f.len = 10'(VALUE_LEN_MAX);
      end else begin
         f.len = d[9:0];
      end
      return f;
   endfunction

   assign nlen = (cfg.name_length > 4'(MAX_NAME_BYTES)) ? 4'(MAX_NAME_BYTES)
                                                          : cfg.name_length;
   assign plen = (cfg.prefix_length > 4'(PREFIX_BYTES)) ? 4'(PREFIX_BYTES)
                                                          : cfg.prefix_length;

   assign rq_pop_ok = rsp_pop && (rq_cnt_ff != '0);
   assign fq_take   = fq_out.valid &&
                      ((rq_cnt_ff != RQ_CW'(RQ_DEPTH)) || rq_pop_ok);
   assign rsp_empty = (rq_cnt_ff == '0);
   assign rsp_data  = rq_slot_ff[rq_rd_ff];

   always_comb begin
      class_item_type it;
      finish_type     fin;
      logic [15:0]    pos;
      logic [15:0]    pos1;
      logic           blank;
      logic [7:0]     ref_c;

      it       = fq_out.item;
      phase_in = phase_ff;
      mi_in    = mi_ff;
      ll_in    = ll_ff;
      cs_in    = cs_ff;
      tt_in    = tt_ff;
      sd_in    = sd_ff;
      emit_v   = 1'b0;
      res      = '0;
      pos      = bp_ff;
      pos1     = bp_ff + 16'd1;
      blank    = 1'b0;
      fin      = '0;
      ref_c    = '0;

      if (!sd_ff) begin
         if (it.is_line_end) begin
            if (in_copy(phase_in)) begin
               fin = finish(phase_in, plen, cs_in, pos);
               if (fin.hit) begin
                  emit_v = 1'b1;
                  res    = '{found: 1'b1, value_start: fin.start, value_length: fin.len};
               end else begin
                  phase_in = PH_IGNORE;
               end
            end
            if (!emit_v) begin
               if (it.is_lf) begin
                  if (tt_in == TT_IN_LINE) begin
                     tt_in = TT_AFTER_LF;
                  end else begin
                     blank = 1'b1;
                  end
               end else begin
                  tt_in = (tt_in == TT_AFTER_LF) ? TT_AFTER_LF_CR : TT_IN_LINE;
               end
               if (blank) begin
                  emit_v = 1'b1;
                  res    = '0;
               end else begin
                  phase_in = PH_NAME;
                  mi_in    = '0;
                  ll_in    = '0;
               end
            end
         end else begin
            tt_in = TT_IN_LINE;
            unique case (phase_in)
               PH_NAME: begin
                  if (mi_in < nlen) begin
                     ref_c = fold_byte(cfg.name_chars[{mi_in[2:0], 3'b000} +: 8]);
                     if (it.folded == ref_c) begin
                        mi_in = mi_in + 4'd1;
                     end else begin
                        phase_in = PH_IGNORE;
                     end
                  end else if (it.is_colon || it.is_space) begin
                     phase_in = PH_SKIP;
                  end else begin
                     phase_in = PH_IGNORE;
                  end
               end
               PH_SKIP, PH_PREFIX: begin
                  if (phase_in == PH_SKIP && it.is_space) begin
                     phase_in = PH_SKIP;
                  end else if (phase_in == PH_SKIP && plen == 4'd0) begin
                     cs_in    = pos;
                     phase_in = PH_VALUE;
                  end else begin
                     if (phase_in == PH_SKIP) begin
                        cs_in = pos;
                        mi_in = '0;
                     end
                     ref_c = fold_byte(cfg.prefix_chars[{mi_in[2:0], 3'b000} +: 8]);
                     if (it.folded == ref_c) begin
                        mi_in    = mi_in + 4'd1;
                        phase_in = (mi_in >= plen) ? PH_PREFIX_END : PH_PREFIX;
                     end else begin
                        phase_in = PH_IGNORE;
                     end
                  end
               end
               PH_PREFIX_END: begin
                  phase_in = it.is_letter ? PH_IGNORE : PH_VALUE;
               end
               default: begin
                  phase_in = phase_in;
               end
            endcase
            if (ll_in < LINE_LEN_W'(COPY_CAP)) begin
               ll_in = ll_in + LINE_LEN_W'(1);
            end
            // The visible line copy is full: the line is finished here.
            if (in_copy(phase_in) && ll_in >= LINE_LEN_W'(COPY_CAP)) begin
               fin = finish(phase_in, plen, cs_in, pos1);
               if (fin.hit) begin
                  emit_v = 1'b1;
                  res    = '{found: 1'b1, value_start: fin.start, value_length: fin.len};
               end else begin
                  phase_in = PH_IGNORE;
               end
            end
         end
         // The end of the message counts as a line end.
         if (it.last && !emit_v) begin
            if (in_copy(phase_in)) begin
               fin = finish(phase_in, plen, cs_in, pos1);
               if (fin.hit) begin
                  emit_v = 1'b1;
                  res    = '{found: 1'b1, value_start: fin.start, value_length: fin.len};
               end
            end
            if (!emit_v) begin
               emit_v = 1'b1;
               res    = '0;
            end
         end
         if (emit_v) begin
            sd_in = 1'b1;
         end
      end

      bp_in = pos1;
      if (it.last) begin
         phase_in = PH_NAME;
         mi_in    = '0;
         bp_in    = '0;
         ll_in    = '0;
         cs_in    = '0;
         tt_in    = TT_AFTER_LF;
         sd_in    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_NAME;
         mi_ff    <= '0;
         bp_ff    <= '0;
         ll_ff    <= '0;
         cs_ff    <= '0;
         tt_ff    <= TT_AFTER_LF;
         sd_ff    <= 1'b0;
      end else if (fq_take) begin
         phase_ff <= phase_in;
         mi_ff    <= mi_in;
         bp_ff    <= bp_in;
         ll_ff    <= ll_in;
         cs_ff    <= cs_in;
         tt_ff    <= tt_in;
         sd_ff    <= sd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rq_wr_ff  <= '0;
         rq_rd_ff  <= '0;
         rq_cnt_ff <= '0;
      end else begin
         if (fq_take && emit_v) begin
            rq_wr_ff <= rq_wr_ff + RQ_AW'(1);
         end
         if (rq_pop_ok) begin
            rq_rd_ff <= rq_rd_ff + RQ_AW'(1);
         end
         rq_cnt_ff <= rq_cnt_ff + RQ_CW'(fq_take && emit_v) - RQ_CW'(rq_pop_ok);
      end
   end

   always_ff @(posedge clock) begin
      if (fq_take && emit_v) begin
         rq_slot_ff[rq_wr_ff] <= res;
      end
   end

endmodule

### rtl/core/mhff_checker.sv
// ============================================================================
// MIME header field finder - port checker
// Concurrent checks on the top level's ports, bound to the top level.
// ============================================================================
module mhff_checker (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_push,
   input mhff_pkg::req_item_type  req_data,
   input logic                    req_full,
   input logic                    rsp_empty,
   input logic                    rsp_pop,
   input mhff_pkg::rsp_item_type  rsp_data,
   input logic                    csr_valid,
   input logic                    csr_ready,
   input mhff_pkg::csr_index_type csr_index,
   input logic [63:0]             csr_data
);
   import mhff_pkg::*;

   // The result queue comes out of reset empty and the input queue not full.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (rsp_empty && !req_full))
      else $error("queues not empty after reset");

   // A waiting result that is not taken stays as it is.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_data)))
      else $error("waiting result changed before it was taken");

   // A not-found result carries no offset and no length.
   a_not_found_zero: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_data.found) |->
         (rsp_data.value_start == 16'd0 && rsp_data.value_length == 10'd0))
      else $error("not-found result with a value");

   // The input queue can only fill up through a request.
   a_full_needs_push: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && !$past(req_push) && !$past(req_full)) |-> !req_full)
      else $error("input queue became full without a request");

   // Configuration writes are never held off.
   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("configuration write stalled");

endmodule

bind mime_header_field_finder mhff_checker u_mhff_checker (.*);
